// ===== design/kfat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfat_pkg
// Shared constants and types for the keyed FNV-1a tag block.
// ----------------------------------------------------------------------------
package kfat_pkg;

   // FNV-1a 32-bit constants.
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // Number of key bytes absorbed before and after the message (1 to 16).
   localparam int KEY_BYTES = 16;
   localparam int CNT_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   // Key storage: 16 bytes held in two 64-bit registers.
   localparam int KEY_W     = 128;
   localparam int KIDX_W    = 4;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register index codes (address bit 3).
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   localparam logic [63:0] KEY_LOW_RESET  = 64'h4C2D524144524553;
   localparam logic [63:0] KEY_HIGH_RESET = 64'h314B53502D41524F;

   // Control from the sequencer to the shared FNV step unit.
   typedef struct packed {
      logic       load_basis;
      logic       step;
      logic [7:0] data;
   } absorb_ctrl_type;

endpackage

// ===== design/kfat_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfat_csr
// Register file holding the 128-bit key, written and read over the APB port.
// ----------------------------------------------------------------------------
module kfat_csr
   import kfat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [KEY_W-1:0]      key
);

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic        reg_sel;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KEY_LOW_RESET;
         key_high_ff <= KEY_HIGH_RESET;
      end else if (wr_en) begin
         if (reg_sel == REG_KEY_LOW) begin
            key_low_ff <= csr_pwdata;
         end else begin
            key_high_ff <= csr_pwdata;
         end
      end
   end

   // Read data.
   always_comb begin
      case (reg_sel)
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         default:      csr_prdata = key_low_ff;
      endcase
   end

   assign key = {key_high_ff, key_low_ff};

endmodule

// ===== design/kfat_absorb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfat_absorb
// Shared FNV-1a step unit: holds the running hash and applies one
// xor-and-multiply step per cycle while step is set; load_basis takes priority.
// ----------------------------------------------------------------------------
module kfat_absorb
   import kfat_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  absorb_ctrl_type ctrl,
   output logic [31:0]     hash
);

   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] mixed;
   logic [31:0] product;

   // One FNV-1a step; the product keeps the low 32 bits.
   assign mixed   = hash_ff ^ {24'd0, ctrl.data};
   assign product = mixed * FNV_PRIME;

   always_comb begin
      hash_in = hash_ff;
      if (ctrl.load_basis) begin
         hash_in = FNV_BASIS;
      end else if (ctrl.step) begin
         hash_in = product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= 32'd0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ===== design/keyed_fnv1a_auth_tag.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_fnv1a_auth_tag
// Keyed FNV-1a 32-bit authentication tag over a byte stream.
//
//   Channel  Direction  Contents
//   req_     in         tdata[7:0] data_byte, tuser[0] has_byte, tlast last
//   rsp_     out        tdata[31:0] tag, one item per message
//   csr_     in/out     APB, key_low at 0x0, key_high at 0x8
//
// An item that opens a message loads the basis and absorbs the key prefix one
// byte per cycle in the single multiply step unit, then its own byte; other
// items absorb only their byte. The last item adds a KEY_BYTES-byte suffix
// derived from the key and then loads the tag register, which waits while an earlier tag is not yet taken.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module keyed_fnv1a_auth_tag
   import kfat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tuser,   // [0] has_byte
   input  logic                  req_tlast,
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] tag
   // Configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_BODY,
      ST_SUFFIX,
      ST_STORE
   } state_type;

   state_type       state_ff,  state_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic            in_msg_ff, in_msg_in;
   logic [7:0]      byte_ff,   byte_in;
   logic            has_ff,    has_in;
   logic            last_ff,   last_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_data_ff,  rsp_data_in;

   logic [KEY_W-1:0]  key;
   logic [31:0]       hash;
   logic [KIDX_W-1:0] kidx;
   logic [7:0]        key_byte;
   logic              cnt_last;
   logic              accept;
   logic              out_free;
   absorb_ctrl_type   ctrl;

   kfat_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   kfat_absorb u_absorb (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .hash  (hash)
   );

   // Key byte selected by the phase counter.
   assign kidx     = KIDX_W'(cnt_ff);
   assign key_byte = key[{kidx, 3'b000} +: 8];
   assign cnt_last = (cnt_ff == CNT_W'(KEY_BYTES - 1));

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Sequencer: next state and step control.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      in_msg_in    = in_msg_ff;
      byte_in      = byte_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '{load_basis: 1'b0, step: 1'b0, data: 8'd0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in = req_tdata;
               has_in  = req_tuser;
               last_in = req_tlast;
               cnt_in  = '0;
               if (!in_msg_ff) begin
                  ctrl.load_basis = 1'b1;
                  in_msg_in       = 1'b1;
                  state_in        = ST_PREFIX;
               end else begin
                  state_in = ST_BODY;
               end
            end
         end
         ST_PREFIX: begin
            ctrl.step = 1'b1;
            ctrl.data = key_byte;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            ctrl.step = has_ff;
            ctrl.data = byte_ff;
            cnt_in    = '0;
            state_in  = last_ff ? ST_SUFFIX : ST_IDLE;
         end
         ST_SUFFIX: begin
            ctrl.step = 1'b1;
            ctrl.data = key_byte + 8'(cnt_ff);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            // Load the tag once the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hash;
               in_msg_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      has_ff      <= has_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
